// ===== hdl/int_to_ascii_radix_core_defines.svh =====
// Assertion macros used by the integer-to-text converter top level.
`ifndef INT_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INT_TO_ASCII_RADIX_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, held off during rst.
`define I2A_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, held off during rst.
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/i2a_pkg.sv =====
// Shared types, codes and the digit-to-character function of the converter.
`timescale 1ns / 1ps

package i2a_pkg;

  // Radix selector carried with each request
  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  // Front-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LOAD
  } state_t;

  // Hand-over from the front end to the character emitter
  typedef struct packed {
    logic   load;
    radix_t radix;
    logic   minus;
  } emit_ctl_t;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [3:0] DIGIT_TEN  = 4'd10;

  // Map one digit 0..15 to '0'..'9', 'A'..'F'
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {4'b0000, d};
    end else begin
      c = CHAR_A + {4'b0000, d - DIGIT_TEN};
    end
    return c;
  endfunction

endpackage

// ===== hdl/i2a_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
`timescale 1ns / 1ps

module i2a_dabble #(
  parameter int WORD_BITS = 32,
  parameter int NDEC      = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [WORD_BITS-1:0]   mag,
  output logic                   done,
  output logic [4*NDEC-1:0]      bcd
);

  localparam int CW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] sh;
  logic [4*NDEC-1:0]    adj;
  logic [CW-1:0]        cnt;
  logic                 busy;

  // Add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Count the bit steps and flag the end of the pass
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WORD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the magnitude, most significant bit first, into the BCD register
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= mag;
      bcd <= '0;
    end else if (busy) begin
      sh  <= {sh[WORD_BITS-2:0], 1'b0};
      bcd <= {adj[4*NDEC-2:0], sh[WORD_BITS-1]};
    end
  end

endmodule

// ===== hdl/i2a_emit.sv =====
// Character emitter: shifts digits out most significant first, drops leading zeros.
`timescale 1ns / 1ps

module i2a_emit #(
  parameter int WORD_BITS = 32,
  parameter int NDEC      = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  i2a_pkg::emit_ctl_t   ctl,
  input  logic [4*NDEC-1:0]    digits,
  output logic                 busy,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [7:0] ascii_char
  output logic                 m_tlast    // last
);

  localparam int EW   = 4 * NDEC;
  localparam int NOCT = (WORD_BITS + 2) / 3;
  localparam int NHEX = (WORD_BITS + 3) / 4;
  localparam int CW   = $clog2(EW + 1);

  logic [EW-1:0]    dbuf;
  logic [EW-1:0]    load_buf;
  logic [CW-1:0]    load_cnt;
  logic [CW-1:0]    rem;
  i2a_pkg::radix_t  radix_q;
  logic             minus;
  logic             started;
  logic [3:0]       dig;
  logic [EW-1:0]    dbuf_shift;
  logic             adv;
  logic             skip;
  logic             out_valid;
  logic [7:0]       out_char;
  logic             out_last;

  // Top-align the digits and set the digit count for the radix
  always_comb begin
    unique case (ctl.radix)
      i2a_pkg::RADIX_BIN: begin
        load_buf = digits << (EW - WORD_BITS);
        load_cnt = CW'(WORD_BITS);
      end
      i2a_pkg::RADIX_OCT: begin
        load_buf = digits << (EW - 3 * NOCT);
        load_cnt = CW'(NOCT);
      end
      i2a_pkg::RADIX_DEC: begin
        load_buf = digits;
        load_cnt = CW'(NDEC);
      end
      i2a_pkg::RADIX_HEX: begin
        load_buf = digits << (EW - 4 * NHEX);
        load_cnt = CW'(NHEX);
      end
      default: begin
        load_buf = digits;
        load_cnt = CW'(NDEC);
      end
    endcase
  end

  // Pick the leading digit and the buffer after it is taken
  always_comb begin
    unique case (radix_q)
      i2a_pkg::RADIX_BIN: begin
        dig        = {3'b000, dbuf[EW-1]};
        dbuf_shift = {dbuf[EW-2:0], 1'b0};
      end
      i2a_pkg::RADIX_OCT: begin
        dig        = {1'b0, dbuf[EW-1 -: 3]};
        dbuf_shift = {dbuf[EW-4:0], 3'b000};
      end
      default: begin
        dig        = dbuf[EW-1 -: 4];
        dbuf_shift = {dbuf[EW-5:0], 4'b0000};
      end
    endcase
  end

  // Step when the output register is free or being emptied
  assign adv  = busy && (!out_valid || m_tready);
  assign skip = !minus && !started && (dig == 4'd0) && (rem != CW'(1));

  // Control: sign, leading-zero tracking, digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      minus     <= 1'b0;
      started   <= 1'b0;
      rem       <= '0;
      radix_q   <= i2a_pkg::RADIX_BIN;
      out_valid <= 1'b0;
    end else begin
      if (adv && !skip) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (ctl.load) begin
        busy    <= 1'b1;
        rem     <= load_cnt;
        minus   <= ctl.minus;
        started <= 1'b0;
        radix_q <= ctl.radix;
      end else if (adv) begin
        if (minus) begin
          minus <= 1'b0;
        end else begin
          rem <= rem - 1'b1;
          if (dig != 4'd0) begin
            started <= 1'b1;
          end
          if (rem == CW'(1)) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  // Hold the digit buffer and the output character
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dbuf <= load_buf;
    end else if (adv && !minus) begin
      dbuf <= dbuf_shift;
    end
    if (adv && !skip) begin
      out_char <= minus ? i2a_pkg::CHAR_MINUS : i2a_pkg::digit_char(dig);
      out_last <= !minus && (rem == CW'(1));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_char;
  assign m_tlast  = out_last;

endmodule

// ===== hdl/int_to_ascii_radix_core.sv =====
// Integer to ASCII text converter, radix 2, 8, 10 or 16, top level.
//
// Each request carries a signed value and a radix code; the block returns the
// text one character per output beat, most significant digit first, tlast on
// the final character. Decimal negatives get a leading '-'; other radices show
// the raw bit pattern. A decimal request first passes through the bit-serial
// BCD converter (one magnitude bit per cycle), then the emitter steps once per
// digit position (WORD_BITS*3/10 + 2 positions in decimal, WORD_BITS,
// ceil(WORD_BITS/3) or ceil(WORD_BITS/4) otherwise), leading zeros included,
// plus one step for a '-', and holds while the output is stalled. The next
// request is taken while the previous text is still being emitted, so
// conversion overlaps emission. With the output never stalled, decimal
// requests are paced by the BCD pass; the other radices are paced by the
// emitter's one-digit-per-cycle shifter.
`timescale 1ns / 1ps
`include "int_to_ascii_radix_core_defines.svh"

module int_to_ascii_radix_core #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value, [33:32] radix_code, [39:34] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] ascii_char
  output logic        m_tlast    // last
);

  localparam int NDEC = (WORD_BITS * 3) / 10 + 2;
  localparam int EW   = 4 * NDEC;

  logic signed [31:0]   in_value;
  i2a_pkg::radix_t      in_radix;
  logic [WORD_BITS-1:0] word;
  logic                 in_neg;
  logic [WORD_BITS-1:0] in_mag;
  logic                 accept;
  logic                 dab_start;
  logic                 dab_done;
  logic [EW-1:0]        bcd;
  logic [WORD_BITS-1:0] mag_q;
  i2a_pkg::radix_t      radix_q;
  logic                 neg_q;
  logic [EW-1:0]        digits;
  logic                 emit_busy;
  i2a_pkg::emit_ctl_t   ctl;
  i2a_pkg::state_t      state;
  i2a_pkg::state_t      state_next;

  // Unpack the request and fit the value to the word width
  assign in_value = signed'(s_tdata[31:0]);
  assign in_radix = i2a_pkg::radix_t'(s_tdata[33:32]);
  assign word     = WORD_BITS'(in_value);
  assign in_neg   = (in_radix == i2a_pkg::RADIX_DEC) && word[WORD_BITS-1];
  assign in_mag   = in_neg ? (~word) + {{(WORD_BITS-1){1'b0}}, 1'b1} : word;

  assign accept    = s_tvalid && s_tready;
  assign dab_start = accept && (in_radix == i2a_pkg::RADIX_DEC);

  // Hold the magnitude, radix and sign of the request in hand
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_q   <= in_mag;
      radix_q <= in_radix;
      neg_q   <= in_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2a_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: decimal goes through the BCD pass, the rest go straight to load
  always_comb begin
    state_next = state;
    unique case (state)
      i2a_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (in_radix == i2a_pkg::RADIX_DEC) ? i2a_pkg::ST_CONV
                                                        : i2a_pkg::ST_LOAD;
        end
      end
      i2a_pkg::ST_CONV: begin
        if (dab_done) begin
          state_next = i2a_pkg::ST_LOAD;
        end
      end
      i2a_pkg::ST_LOAD: begin
        if (!emit_busy) begin
          state_next = i2a_pkg::ST_IDLE;
        end
      end
      default: state_next = i2a_pkg::ST_IDLE;
    endcase
  end

  // Outputs: take requests when idle, hand digits over once the emitter frees
  always_comb begin
    s_tready  = (state == i2a_pkg::ST_IDLE);
    ctl.load  = (state == i2a_pkg::ST_LOAD) && !emit_busy;
    ctl.radix = radix_q;
    ctl.minus = neg_q;
  end

  assign digits = (radix_q == i2a_pkg::RADIX_DEC) ? bcd : EW'(mag_q);

  i2a_dabble #(
    .WORD_BITS (WORD_BITS),
    .NDEC      (NDEC)
  ) u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (dab_start),
    .mag   (in_mag),
    .done  (dab_done),
    .bcd   (bcd)
  );

  i2a_emit #(
    .WORD_BITS (WORD_BITS),
    .NDEC      (NDEC)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .digits   (digits),
    .busy     (emit_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `I2A_ASSERT_NEXT(a_dec_enters_conv, dab_start, state == i2a_pkg::ST_CONV, "no BCD pass")
  `I2A_ASSERT_IMPL(a_done_in_conv, dab_done, state == i2a_pkg::ST_CONV, "stray BCD done")
  `I2A_ASSERT_NEXT(a_load_makes_busy, ctl.load, emit_busy, "emitter did not take the digits")
  `I2A_ASSERT_IMPL(a_minus_dec, ctl.load && neg_q, radix_q == i2a_pkg::RADIX_DEC, "bad sign")

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the integer-to-ASCII converter: directed table, then random requests.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT_CYCLES = 600000;
  localparam int RANDOM_ITEMS = 245;
  localparam int DRAIN_CYCLES = 120;
  localparam int TABLE_ROWS   = 25;

  // One expected output character
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // One directed request; an empty text means the predictor supplies the answer
  typedef struct {
    logic [31:0]     value;
    i2a_pkg::radix_t radix;
    string           text;
  } text_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  text_char_t  pending_text[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          sender_burst = 1'b0;
  bit          receiver_burst = 1'b0;

  text_row_t   text_table[TABLE_ROWS] = '{
    '{32'd0,          i2a_pkg::RADIX_BIN, "0"},
    '{32'd0,          i2a_pkg::RADIX_OCT, "0"},
    '{32'd0,          i2a_pkg::RADIX_DEC, "0"},
    '{32'd0,          i2a_pkg::RADIX_HEX, "0"},
    '{32'd1,          i2a_pkg::RADIX_BIN, "1"},
    '{32'd7,          i2a_pkg::RADIX_OCT, "7"},
    '{32'd9,          i2a_pkg::RADIX_DEC, "9"},
    '{32'd15,         i2a_pkg::RADIX_HEX, "F"},
    '{32'h7FFFFFFF,   i2a_pkg::RADIX_DEC, "2147483647"},
    '{32'h80000000,   i2a_pkg::RADIX_DEC, "-2147483648"},
    '{32'hFFFFFFFF,   i2a_pkg::RADIX_DEC, "-1"},
    '{32'hFFFFFFFF,   i2a_pkg::RADIX_BIN, "11111111111111111111111111111111"},
    '{32'hFFFFFFFF,   i2a_pkg::RADIX_OCT, "37777777777"},
    '{32'hFFFFFFFF,   i2a_pkg::RADIX_HEX, "FFFFFFFF"},
    '{32'h80000000,   i2a_pkg::RADIX_HEX, "80000000"},
    '{32'h80000000,   i2a_pkg::RADIX_BIN, "10000000000000000000000000000000"},
    '{32'h80000000,   i2a_pkg::RADIX_OCT, "20000000000"},
    '{32'h7FFFFFFF,   i2a_pkg::RADIX_HEX, "7FFFFFFF"},
    '{32'hABCDEF01,   i2a_pkg::RADIX_HEX, ""},
    '{32'h12345678,   i2a_pkg::RADIX_DEC, ""},
    '{-32'sd12345,    i2a_pkg::RADIX_DEC, ""},
    '{32'd10,         i2a_pkg::RADIX_HEX, "A"},
    '{32'd8,          i2a_pkg::RADIX_OCT, "10"},
    '{32'd2,          i2a_pkg::RADIX_BIN, "10"},
    '{32'd1000000000, i2a_pkg::RADIX_DEC, ""}
  };

  int_to_ascii_radix_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Free-running clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d characters outstanding",
               cycle_count, pending_text.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
  endtask

  // Queue the characters of a typed-in string, last flag on the final one
  task automatic queue_literal_text(input string text);
    text_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.ch   = text[i];
      c.last = (i == text.len() - 1);
      pending_text.push_back(c);
    end
  endtask

  // Work out the text of one request and queue it
  task automatic predict_text(input logic [31:0] value, input i2a_pkg::radix_t radix);
    string       digit_set;
    logic [31:0] mag;
    logic [31:0] base;
    logic [7:0]  rev_digits[40];
    int          ndig;
    text_char_t  c;
    digit_set = "0123456789ABCDEF";
    ndig = 0;
    case (radix)
      i2a_pkg::RADIX_BIN: base = 32'd2;
      i2a_pkg::RADIX_OCT: base = 32'd8;
      i2a_pkg::RADIX_DEC: base = 32'd10;
      default:            base = 32'd16;
    endcase
    // Only decimal treats the word as signed
    if (radix == i2a_pkg::RADIX_DEC && value[31]) begin
      mag    = 32'd0 - value;
      c.ch   = "-";
      c.last = 1'b0;
      pending_text.push_back(c);
    end else begin
      mag = value;
    end
    do begin
      rev_digits[ndig] = digit_set[mag % base];
      ndig++;
      mag = mag / base;
    end while (mag != 32'd0);
    for (int k = ndig - 1; k >= 0; k--) begin
      c.ch   = rev_digits[k];
      c.last = (k == 0);
      pending_text.push_back(c);
    end
  endtask

  // Present one request after a random gap and hold it until taken
  task automatic send_request(input logic [31:0] value, input i2a_pkg::radix_t radix);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b000000, radix, value};
    do @(posedge clk); while (!s_tready);
  endtask

  // Wait until every queued character has come out
  task automatic wait_for_drain();
    while (pending_text.size() != 0) @(posedge clk);
  endtask

  // Draw a value biased towards the interesting corners
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = $urandom_range(0, 20);
      1:       v = 32'd0 - $urandom_range(1, 20);
      2:       v = 32'd1 << $urandom_range(0, 31);
      3:       v = (32'd1 << $urandom_range(0, 31)) - 32'd1;
      4:       v = $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Stimulus: reset, directed table, random requests, drain
  initial begin
    logic [31:0]     value;
    i2a_pkg::radix_t radix;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (text_table[i]) begin
      send_request(text_table[i].value, text_table[i].radix);
      if (text_table[i].text.len() != 0) begin
        queue_literal_text(text_table[i].text);
      end else begin
        predict_text(text_table[i].value, text_table[i].radix);
      end
    end

    // Hold off until the output side has caught up
    s_tvalid <= 1'b0;
    wait_for_drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) sender_burst = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_ITEMS / 2) begin
        s_tvalid <= 1'b0;
        wait_for_drain();
      end
      value = pick_value();
      radix = i2a_pkg::radix_t'($urandom_range(0, 3));
      send_request(value, radix);
      predict_text(value, radix);
    end
    s_tvalid <= 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_text.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Output back-pressure: random stall before each character, with quiet stretches
  initial begin
    int gap;
    int count;
    count = 0;
    while (rst) @(posedge clk);
    forever begin
      if (count % 50 == 0) receiver_burst = ($urandom_range(0, 2) == 0);
      count++;
      gap = receiver_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Check each character against the oldest expectation
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_text.size() == 0) begin
        report_mismatch("ascii_char with nothing pending", m_tdata, 8'h00);
      end else begin
        want = pending_text.pop_front();
        if (m_tdata !== want.ch) report_mismatch("ascii_char", m_tdata, want.ch);
        if (m_tlast !== want.last) report_mismatch("last", {7'd0, m_tlast}, {7'd0, want.last});
      end
    end
  end

endmodule

// ===== int_to_ascii_radix_core.f =====
+incdir+hdl
hdl/i2a_pkg.sv
hdl/i2a_dabble.sv
hdl/i2a_emit.sv
hdl/int_to_ascii_radix_core.sv
tb/testbench.sv
